// ===== hdl/fbct_pkg.sv =====
// shared types and constants for the block chain table
package fbct_pkg;

    // table geometry
    localparam int BLOCK_COUNT = 256;
    localparam int ADDR_W      = $clog2(BLOCK_COUNT);
    localparam int SCAN_W      = ADDR_W + 1;
    localparam int ENTRY_W     = $clog2(BLOCK_COUNT + 2);

    // fixed field widths of the stream items
    localparam int OP_W     = 3;
    localparam int BLK_W    = 8;
    localparam int STEPS_W  = 8;
    localparam int STATUS_W = 2;
    localparam int FREED_W  = 9;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    // entry codes above the link range
    localparam logic [ENTRY_W-1:0] MARK_END  = ENTRY_W'(BLOCK_COUNT);
    localparam logic [ENTRY_W-1:0] MARK_FREE = ENTRY_W'(BLOCK_COUNT + 1);

    typedef enum logic [OP_W-1:0] {
        OP_NEW    = 3'd0,
        OP_EXTEND = 3'd1,
        OP_FREE   = 3'd2,
        OP_NEXT   = 3'd3,
        OP_WALK   = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_BAD    = 2'd2,
        STAT_BROKEN = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_LINK,
        S_FREE,
        S_NEXT,
        S_WALK,
        S_DONE
    } state_t;

    // one result item
    typedef struct packed {
        logic [FREED_W-1:0] freed_count;
        logic               at_end;
        logic [BLK_W-1:0]   result_block;
        status_t            status;
    } result_t;

    // table memory access from the engine
    typedef struct packed {
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [ENTRY_W-1:0] wr_data;
        logic               rd_en;
        logic [ADDR_W-1:0]  rd_addr;
    } ram_req_t;

endpackage

// ===== hdl/fat_block_chain_table.sv =====
// Block chain table (file allocation table) with one result item per request item.
// After reset the table is swept to its initial contents (block 0 an end mark, all
// others free), during which s_tready stays low. Each item then runs on its own
// through a sequencer around one table memory with a registered read: the
// free-block search of new and extend passes over allocated entries in turn (it
// starts at the lowest block that may be free), free frees the chain block by block
// and walk follows its links one by one. A finished result sits in an output
// register, so the next item is taken while it waits on m_tready.
module fat_block_chain_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [2:0] op, [10:3] block, [18:11] steps, [23:19] zero
    input  logic [fbct_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] status, [9:2] result_block, [10] at_end, [19:11] freed_count, [23:20] zero
    output logic [fbct_pkg::M_DATA_W-1:0] m_tdata
);
    import fbct_pkg::*;

    ram_req_t            ram_req;
    logic [ENTRY_W-1:0]  ram_rd_data;
    logic                res_push;
    result_t             res;
    logic                out_room;

    // chain table storage
    fbct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BLOCK_COUNT)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data)
    );

    // request sequencer
    fbct_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tdata[2:0]),
        .in_block    (s_tdata[10:3]),
        .in_steps    (s_tdata[18:11]),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data),
        .res_push    (res_push),
        .res         (res),
        .out_room    (out_room)
    );

    // result register
    fbct_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_push (res_push),
        .res      (res),
        .out_room (out_room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== hdl/fbct_ram.sv =====
// generic single write port, single read port ram with registered read
module fbct_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, old data on a same-address collision
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/fbct_engine.sv =====
// request sequencer: reads, modifies and writes back the chain table
module fbct_engine (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [fbct_pkg::OP_W-1:0]    in_op,
    input  logic [fbct_pkg::BLK_W-1:0]   in_block,
    input  logic [fbct_pkg::STEPS_W-1:0] in_steps,
    output fbct_pkg::ram_req_t        ram_req,
    input  logic [fbct_pkg::ENTRY_W-1:0] ram_rd_data,
    output logic                      res_push,
    output fbct_pkg::result_t         res,
    input  logic                      out_room
);
    import fbct_pkg::*;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [ADDR_W-1:0]    cur_reg, cur_next;
    logic [ADDR_W-1:0]    prev_reg, prev_next;
    logic [STEPS_W-1:0]   steps_reg, steps_next;
    logic                 first_reg, first_next;
    logic [SCAN_W-1:0]    scan_reg, scan_next;
    logic [SCAN_W-1:0]    hint_reg, hint_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    result_t              pend_reg, pend_next;

    logic                 in_acc;
    logic                 blk_oor;
    logic                 d_free;
    logic                 d_end;
    logic [ADDR_W-1:0]    d_link;
    logic                 clr_last;
    logic                 scan_none;
    logic                 scan_last;
    logic [SCAN_W-1:0]    scan_inc;

    // handshake, range check and decode of the entry just read
    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign blk_oor   = (SCAN_W'(in_block) >= SCAN_W'(BLOCK_COUNT));
    assign d_free    = (ram_rd_data == MARK_FREE);
    assign d_end     = (ram_rd_data == MARK_END);
    assign d_link    = ram_rd_data[ADDR_W-1:0];
    assign clr_last  = (clr_reg == ADDR_W'(BLOCK_COUNT - 1));
    assign scan_none = (scan_reg == SCAN_W'(BLOCK_COUNT));
    assign scan_inc  = scan_reg + SCAN_W'(1);
    assign scan_last = (scan_inc == SCAN_W'(BLOCK_COUNT));
    assign res       = pend_reg;
    assign res_push  = (state_reg == S_DONE) && out_room;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    case (op_t'(in_op))
                        OP_NEW:    state_next = S_SCAN_RD;
                        OP_EXTEND: state_next = blk_oor ? S_DONE : S_EXT;
                        OP_FREE:   state_next = blk_oor ? S_DONE : S_FREE;
                        OP_NEXT:   state_next = blk_oor ? S_DONE : S_NEXT;
                        OP_WALK:   state_next = blk_oor ? S_DONE : S_WALK;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_EXT: begin
                state_next = (!d_free && d_end) ? S_SCAN_RD : S_DONE;
            end
            S_SCAN_RD: begin
                state_next = scan_none ? S_DONE : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (d_free) begin
                    state_next = (op_reg == OP_EXTEND) ? S_LINK : S_DONE;
                end else if (scan_last) begin
                    state_next = S_DONE;
                end
            end
            S_LINK: begin
                state_next = S_DONE;
            end
            S_FREE: begin
                if (d_free || d_end || d_link == cur_reg) begin
                    state_next = S_DONE;
                end
            end
            S_NEXT: begin
                state_next = S_DONE;
            end
            S_WALK: begin
                if (d_free || d_end || steps_reg == '0) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_room) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // datapath and table accesses
    always_comb begin
        op_next    = op_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        steps_next = steps_reg;
        first_next = first_reg;
        scan_next  = scan_reg;
        hint_next  = hint_reg;
        clr_next   = clr_reg;
        pend_next  = pend_reg;
        ram_req    = '0;
        unique case (state_reg)
            S_CLEAR: begin
                // sweep the table to its reset contents
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = clr_reg;
                ram_req.wr_data = (clr_reg == '0) ? MARK_END : MARK_FREE;
                clr_next        = clr_reg + ADDR_W'(1);
            end
            S_IDLE: begin
                if (in_acc) begin
                    op_next         = op_t'(in_op);
                    cur_next        = ADDR_W'(in_block);
                    steps_next      = in_steps;
                    first_next      = 1'b1;
                    scan_next       = hint_reg;
                    pend_next       = '0;
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = ADDR_W'(in_block);
                    case (op_t'(in_op)) inside
                        OP_NEW: ;
                        OP_EXTEND, OP_FREE, OP_NEXT, OP_WALK: begin
                            if (blk_oor) begin
                                pend_next.status = STAT_BAD;
                            end
                        end
                        default: pend_next.status = STAT_BAD;
                    endcase
                end
            end
            S_EXT: begin
                // the block to extend must be a chain tail
                if (d_free || !d_end) begin
                    pend_next.status = STAT_BAD;
                end
            end
            S_SCAN_RD: begin
                if (scan_none) begin
                    pend_next.status = STAT_FULL;
                end else begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = scan_reg[ADDR_W-1:0];
                end
            end
            S_SCAN_CHK: begin
                // lowest free block search, one entry a cycle
                if (d_free) begin
                    ram_req.wr_en          = 1'b1;
                    ram_req.wr_addr        = scan_reg[ADDR_W-1:0];
                    ram_req.wr_data        = MARK_END;
                    hint_next              = scan_inc;
                    pend_next.result_block = BLK_W'(scan_reg);
                    pend_next.at_end       = 1'b1;
                end else if (scan_last) begin
                    pend_next.status = STAT_FULL;
                    hint_next        = scan_inc;
                end else begin
                    scan_next       = scan_inc;
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = scan_inc[ADDR_W-1:0];
                end
            end
            S_LINK: begin
                // old tail now points at the new block
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = cur_reg;
                ram_req.wr_data = ENTRY_W'(scan_reg);
            end
            S_FREE: begin
                // free one block a cycle while reading its successor
                if (d_free) begin
                    pend_next.status = first_reg ? STAT_BAD : STAT_BROKEN;
                end else begin
                    first_next            = 1'b0;
                    ram_req.wr_en         = 1'b1;
                    ram_req.wr_addr       = cur_reg;
                    ram_req.wr_data       = MARK_FREE;
                    pend_next.freed_count = pend_reg.freed_count + FREED_W'(1);
                    if (SCAN_W'(cur_reg) < hint_reg) begin
                        hint_next = SCAN_W'(cur_reg);
                    end
                    if (d_end) begin
                        pend_next.status = STAT_OK;
                    end else if (d_link == cur_reg) begin
                        // self link points at the block just freed
                        pend_next.status = STAT_BROKEN;
                    end else begin
                        cur_next        = d_link;
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = d_link;
                    end
                end
            end
            S_NEXT: begin
                if (d_free) begin
                    pend_next.status = STAT_BAD;
                end else if (d_end) begin
                    pend_next.at_end = 1'b1;
                end else begin
                    pend_next.result_block = BLK_W'(d_link);
                end
            end
            S_WALK: begin
                // follow one link a cycle
                if (d_free) begin
                    if (first_reg) begin
                        pend_next.status = STAT_BAD;
                    end else begin
                        pend_next.status       = STAT_BROKEN;
                        pend_next.result_block = BLK_W'(prev_reg);
                    end
                end else begin
                    first_next = 1'b0;
                    if (steps_reg == '0) begin
                        pend_next.result_block = BLK_W'(cur_reg);
                        pend_next.at_end       = d_end;
                    end else if (d_end) begin
                        pend_next.status       = STAT_BROKEN;
                        pend_next.result_block = BLK_W'(cur_reg);
                        pend_next.at_end       = 1'b1;
                    end else begin
                        prev_next       = cur_reg;
                        cur_next        = d_link;
                        steps_next      = steps_reg - STEPS_W'(1);
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = d_link;
                    end
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            hint_reg  <= SCAN_W'(1);
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            hint_reg  <= hint_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        steps_reg <= steps_next;
        first_reg <= first_next;
        scan_reg  <= scan_next;
        pend_reg  <= pend_next;
    end

endmodule

// ===== hdl/fbct_out_reg.sv =====
// result output register that frees the engine while an item waits
module fbct_out_reg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          res_push,
    input  fbct_pkg::result_t             res,
    output logic                          out_room,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fbct_pkg::M_DATA_W-1:0] m_tdata
);
    import fbct_pkg::*;

    logic                valid_reg, valid_next;
    logic [M_DATA_W-1:0] data_reg, data_next;

    assign out_room = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    // load on push, drop when taken
    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (res_push) begin
            valid_next = 1'b1;
            data_next  = M_DATA_W'({res.freed_count, res.at_end,
                                    res.result_block, res.status});
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule
